>>> hw/rtl/raa_pkg.sv
// Shared types and constants for the rectangle area allocator.
// Used by raa_ctrl, raa_dpath and rect_atlas_area_allocator_unit; no dependencies.
package raa_pkg;

   localparam int MAX_FREE_RECTS_DEF = 64;
   localparam int COORD_BITS_DEF     = 12;
   localparam int FIELD_W            = 12;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RESTART,
      ST_SCAN_RD,
      ST_SCAN_MUL,
      ST_SCAN_CMP,
      ST_PLACE,
      ST_PART_RD,
      ST_PART_WR,
      ST_SPLIT_RD,
      ST_SPLIT_WR,
      ST_PRUNE_I,
      ST_PRUNE_LATCH,
      ST_PRUNE_J,
      ST_PRUNE_CHK,
      ST_COMP_RD,
      ST_COMP_WR
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_RESTART,
      OP_SCAN_RD,
      OP_SCAN_MUL,
      OP_SCAN_CMP,
      OP_PLACE,
      OP_PART_RD,
      OP_PART_WR,
      OP_PART_END,
      OP_SPLIT_RD,
      OP_SPLIT_WR,
      OP_SPLIT_END,
      OP_PRUNE_RD_I,
      OP_PRUNE_LATCH,
      OP_PRUNE_NEXT_I,
      OP_PRUNE_RD_J,
      OP_PRUNE_CHK,
      OP_PRUNE_END,
      OP_COMP_RD,
      OP_COMP_WR,
      OP_COMP_END
   } op_type;

   typedef struct packed {
      logic i_end;
      logic j_end;
      logic found;
      logic hold_end;
      logic rem_last;
      logic rd_dead;
      logic kill_i;
   } status_type;

endpackage

>>> hw/rtl/rect_atlas_area_allocator_unit.sv
// Rectangle area allocator with a maximal free rectangle list, best area fit.
// A restart replaces the list with one free rectangle of the requested size; a reserve runs
// a best fit scan, a partition, a split, a containment cleanup and a compaction of the list,
// one item at a time.
// Reset is synchronous and empties the list; the receiver takes each beat as it comes.
module rect_atlas_area_allocator_unit #(
   parameter int MAX_FREE_RECTS = raa_pkg::MAX_FREE_RECTS_DEF,
   parameter int COORD_BITS     = raa_pkg::COORD_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_kind,
   input  logic [raa_pkg::FIELD_W-1:0] req_width,
   input  logic [raa_pkg::FIELD_W-1:0] req_height,
   output logic                        rsp_valid,
   output logic                        rsp_granted,
   output logic [raa_pkg::FIELD_W-1:0] rsp_pos_x,
   output logic [raa_pkg::FIELD_W-1:0] rsp_pos_y,
   output logic                        rsp_list_overflow
);
   import raa_pkg::*;

   op_type     op;
   status_type status;

   raa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_kind  (req_kind),
      .status    (status),
      .op        (op),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   raa_dpath #(
      .MAX_FREE_RECTS (MAX_FREE_RECTS),
      .COORD_BITS     (COORD_BITS)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .op            (op),
      .req_width     (req_width),
      .req_height    (req_height),
      .status        (status),
      .granted       (rsp_granted),
      .pos_x         (rsp_pos_x),
      .pos_y         (rsp_pos_y),
      .list_overflow (rsp_list_overflow)
   );

   a_rsp_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("Result beat outside a busy period.");

   a_rsp_ends_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy && !rsp_valid)
      else $error("Item did not finish after its result beat.");

   a_accept_goes_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("Accepted item did not make the block busy.");

   a_fail_is_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_granted |->
         rsp_pos_x == '0 && rsp_pos_y == '0 && !rsp_list_overflow)
      else $error("Failed reserve reported a position or overflow.");

endmodule

>>> hw/rtl/raa_ctrl.sv
// Sequencing state machine of the rectangle area allocator.
// Depends on raa_pkg; drives raa_dpath through an operation code.
module raa_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                req_kind,
   input  raa_pkg::status_type status,
   output raa_pkg::op_type     op,
   output logic                busy,
   output logic                rsp_valid
);
   import raa_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      done_ff;
   logic      done_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      done_in  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start && !done_ff) begin
               state_in = req_kind ? ST_RESTART : ST_SCAN_RD;
            end
         end
         ST_RESTART: begin
            state_in = ST_IDLE;
            done_in  = 1'b1;
         end
         ST_SCAN_RD: begin
            if (status.i_end) begin
               if (status.found) begin
                  state_in = ST_PLACE;
               end else begin
                  state_in = ST_IDLE;
                  done_in  = 1'b1;
               end
            end else begin
               state_in = ST_SCAN_MUL;
            end
         end
         ST_SCAN_MUL:    state_in = ST_SCAN_CMP;
         ST_SCAN_CMP:    state_in = ST_SCAN_RD;
         ST_PLACE:       state_in = ST_PART_RD;
         ST_PART_RD:     state_in = status.i_end ? ST_SPLIT_RD : ST_PART_WR;
         ST_PART_WR:     state_in = ST_PART_RD;
         ST_SPLIT_RD:    state_in = status.hold_end ? ST_PRUNE_I : ST_SPLIT_WR;
         ST_SPLIT_WR:    state_in = status.rem_last ? ST_SPLIT_RD : ST_SPLIT_WR;
         ST_PRUNE_I:     state_in = status.i_end ? ST_COMP_RD : ST_PRUNE_LATCH;
         ST_PRUNE_LATCH: state_in = status.rd_dead ? ST_PRUNE_I : ST_PRUNE_J;
         ST_PRUNE_J:     state_in = status.j_end ? ST_PRUNE_I : ST_PRUNE_CHK;
         ST_PRUNE_CHK:   state_in = status.kill_i ? ST_PRUNE_I : ST_PRUNE_J;
         ST_COMP_RD: begin
            if (status.i_end) begin
               state_in = ST_IDLE;
               done_in  = 1'b1;
            end else begin
               state_in = ST_COMP_WR;
            end
         end
         ST_COMP_WR:     state_in = ST_COMP_RD;
         default:        state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      op = OP_NONE;
      case (state_ff)
         ST_IDLE:        op = (start && !done_ff) ? OP_LOAD : OP_NONE;
         ST_RESTART:     op = OP_RESTART;
         ST_SCAN_RD:     op = status.i_end ? OP_NONE : OP_SCAN_RD;
         ST_SCAN_MUL:    op = OP_SCAN_MUL;
         ST_SCAN_CMP:    op = OP_SCAN_CMP;
         ST_PLACE:       op = OP_PLACE;
         ST_PART_RD:     op = status.i_end ? OP_PART_END : OP_PART_RD;
         ST_PART_WR:     op = OP_PART_WR;
         ST_SPLIT_RD:    op = status.hold_end ? OP_SPLIT_END : OP_SPLIT_RD;
         ST_SPLIT_WR:    op = OP_SPLIT_WR;
         ST_PRUNE_I:     op = status.i_end ? OP_PRUNE_END : OP_PRUNE_RD_I;
         ST_PRUNE_LATCH: op = OP_PRUNE_LATCH;
         ST_PRUNE_J:     op = status.j_end ? OP_PRUNE_NEXT_I : OP_PRUNE_RD_J;
         ST_PRUNE_CHK:   op = OP_PRUNE_CHK;
         ST_COMP_RD:     op = status.i_end ? OP_COMP_END : OP_COMP_RD;
         ST_COMP_WR:     op = OP_COMP_WR;
         default:        op = OP_NONE;
      endcase
   end

   assign busy      = (state_ff != ST_IDLE) || done_ff;
   assign rsp_valid = done_ff;

endmodule

>>> hw/rtl/raa_dpath.sv
// Datapath of the rectangle area allocator: free list and hold memories,
// indices, area multiplier and result registers. Depends on raa_pkg.
module raa_dpath #(
   parameter int MAX_FREE_RECTS = raa_pkg::MAX_FREE_RECTS_DEF,
   parameter int COORD_BITS     = raa_pkg::COORD_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  raa_pkg::op_type             op,
   input  logic [raa_pkg::FIELD_W-1:0] req_width,
   input  logic [raa_pkg::FIELD_W-1:0] req_height,
   output raa_pkg::status_type         status,
   output logic                        granted,
   output logic [raa_pkg::FIELD_W-1:0] pos_x,
   output logic [raa_pkg::FIELD_W-1:0] pos_y,
   output logic                        list_overflow
);
   import raa_pkg::*;

   localparam int C      = COORD_BITS;
   localparam int IDX_W  = $clog2(MAX_FREE_RECTS);
   localparam int CNT_W  = $clog2(MAX_FREE_RECTS + 1);
   localparam int RECT_W = 4 * C;
   localparam int WORD_W = RECT_W + 1;
   localparam logic [1:0] REM_LAST = 2'd3;

   logic [WORD_W-1:0] mem [MAX_FREE_RECTS];
   logic [RECT_W-1:0] hold_mem [MAX_FREE_RECTS];

   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  i_ff, i_in;
   logic [CNT_W-1:0]  j_ff, j_in;
   logic [CNT_W-1:0]  wp_ff, wp_in;
   logic [CNT_W-1:0]  hcnt_ff, hcnt_in;
   logic [CNT_W-1:0]  hidx_ff, hidx_in;
   logic [1:0]        rem_ff, rem_in;
   logic [C-1:0]      w_ff, w_in;
   logic [C-1:0]      h_ff, h_in;
   logic              found_ff, found_in;
   logic [2*C-1:0]    best_area_ff, best_area_in;
   logic [C-1:0]      best_l_ff, best_l_in;
   logic [C-1:0]      best_t_ff, best_t_in;
   logic [2*C-1:0]    area_ff, area_in;
   logic              fits_ff, fits_in;
   logic [C-1:0]      res_l_ff, res_l_in;
   logic [C-1:0]      res_t_ff, res_t_in;
   logic [C:0]        res_r_ff, res_r_in;
   logic [C:0]        res_b_ff, res_b_in;
   logic              granted_ff, granted_in;
   logic              ovf_ff, ovf_in;
   logic [RECT_W-1:0] ri_ff, ri_in;
   logic [WORD_W-1:0] rd_ff;
   logic [RECT_W-1:0] hrd_ff;

   logic              mem_we, mem_re, hold_we, hold_re;
   logic [IDX_W-1:0]  mem_waddr, mem_raddr, hold_waddr;
   logic [WORD_W-1:0] mem_wdata;

   logic [C-1:0] o_l, o_t, o_r, o_b, k_l, k_t, k_r, k_b, h_l, h_t, h_r, h_b;
   logic [C-1:0] fw, fh;
   logic         overlap, in_ij, in_ji, rem_cond, room, better;
   logic [RECT_W-1:0] nr;

   assign o_l = rd_ff[C-1:0];
   assign o_t = rd_ff[2*C-1:C];
   assign o_r = rd_ff[3*C-1:2*C];
   assign o_b = rd_ff[4*C-1:3*C];
   assign k_l = ri_ff[C-1:0];
   assign k_t = ri_ff[2*C-1:C];
   assign k_r = ri_ff[3*C-1:2*C];
   assign k_b = ri_ff[4*C-1:3*C];
   assign h_l = hrd_ff[C-1:0];
   assign h_t = hrd_ff[2*C-1:C];
   assign h_r = hrd_ff[3*C-1:2*C];
   assign h_b = hrd_ff[4*C-1:3*C];

   assign fw = (o_r > o_l) ? o_r - o_l : '0;
   assign fh = (o_b > o_t) ? o_b - o_t : '0;

   assign overlap = (res_r_ff > {1'b0, o_l}) && (res_l_ff < o_r) &&
                    (res_b_ff > {1'b0, o_t}) && (res_t_ff < o_b);
   assign in_ij = (k_l >= o_l) && (k_t >= o_t) && (k_r <= o_r) && (k_b <= o_b);
   assign in_ji = (o_l >= k_l) && (o_t >= k_t) && (o_r <= k_r) && (o_b <= k_b);
   assign better = fits_ff && (!found_ff || (area_ff < best_area_ff));
   assign room = (count_ff < CNT_W'(MAX_FREE_RECTS));

   always_comb begin
      rem_cond = 1'b0;
      nr       = hrd_ff;
      case (rem_ff)
         2'd0: begin
            rem_cond = res_r_ff < {1'b0, h_r};
            nr       = {h_b, h_r, h_t, res_r_ff[C-1:0]};
         end
         2'd1: begin
            rem_cond = res_l_ff > h_l;
            nr       = {h_b, res_l_ff, h_t, h_l};
         end
         2'd2: begin
            rem_cond = res_b_ff < {1'b0, h_b};
            nr       = {h_b, h_r, res_b_ff[C-1:0], h_l};
         end
         default: begin
            rem_cond = res_t_ff > h_t;
            nr       = {res_t_ff, h_r, h_t, h_l};
         end
      endcase
   end

   assign status.i_end    = (i_ff == count_ff);
   assign status.j_end    = (j_ff == count_ff);
   assign status.found    = found_ff;
   assign status.hold_end = (hidx_ff == hcnt_ff);
   assign status.rem_last = (rem_ff == REM_LAST);
   assign status.rd_dead  = rd_ff[RECT_W];
   assign status.kill_i   = !rd_ff[RECT_W] && in_ij;

   always_comb begin
      count_in     = count_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      wp_in        = wp_ff;
      hcnt_in      = hcnt_ff;
      hidx_in      = hidx_ff;
      rem_in       = rem_ff;
      w_in         = w_ff;
      h_in         = h_ff;
      found_in     = found_ff;
      best_area_in = best_area_ff;
      best_l_in    = best_l_ff;
      best_t_in    = best_t_ff;
      area_in      = area_ff;
      fits_in      = fits_ff;
      res_l_in     = res_l_ff;
      res_t_in     = res_t_ff;
      res_r_in     = res_r_ff;
      res_b_in     = res_b_ff;
      granted_in   = granted_ff;
      ovf_in       = ovf_ff;
      ri_in        = ri_ff;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      hold_we      = 1'b0;
      hold_re      = 1'b0;
      mem_waddr    = i_ff[IDX_W-1:0];
      mem_raddr    = i_ff[IDX_W-1:0];
      hold_waddr   = hcnt_ff[IDX_W-1:0];
      mem_wdata    = {1'b0, rd_ff[RECT_W-1:0]};
      case (op)
         OP_LOAD: begin
            w_in       = C'(req_width);
            h_in       = C'(req_height);
            i_in       = '0;
            found_in   = 1'b0;
            granted_in = 1'b0;
            ovf_in     = 1'b0;
            res_l_in   = '0;
            res_t_in   = '0;
         end
         OP_RESTART: begin
            mem_we     = 1'b1;
            mem_waddr  = '0;
            mem_wdata  = {1'b0, h_ff, w_ff, {C{1'b0}}, {C{1'b0}}};
            count_in   = CNT_W'(1);
            granted_in = 1'b1;
         end
         OP_SCAN_RD: mem_re = 1'b1;
         OP_SCAN_MUL: begin
            fits_in = (fw >= w_ff) && (fh >= h_ff);
            area_in = fw * fh;
         end
         OP_SCAN_CMP: begin
            if (better) begin
               found_in     = 1'b1;
               best_area_in = area_ff;
               best_l_in    = o_l;
               best_t_in    = o_t;
            end
            i_in = i_ff + CNT_W'(1);
         end
         OP_PLACE: begin
            res_l_in   = best_l_ff;
            res_t_in   = best_t_ff;
            res_r_in   = {1'b0, best_l_ff} + {1'b0, w_ff};
            res_b_in   = {1'b0, best_t_ff} + {1'b0, h_ff};
            granted_in = 1'b1;
            i_in       = '0;
            wp_in      = '0;
            hcnt_in    = '0;
         end
         OP_PART_RD: mem_re = 1'b1;
         OP_PART_WR: begin
            if (overlap) begin
               hold_we = 1'b1;
               hcnt_in = hcnt_ff + CNT_W'(1);
            end else begin
               mem_we    = 1'b1;
               mem_waddr = wp_ff[IDX_W-1:0];
               wp_in     = wp_ff + CNT_W'(1);
            end
            i_in = i_ff + CNT_W'(1);
         end
         OP_PART_END: begin
            count_in = wp_ff;
            hidx_in  = '0;
         end
         OP_SPLIT_RD: begin
            hold_re = 1'b1;
            rem_in  = '0;
         end
         OP_SPLIT_WR: begin
            if (rem_cond) begin
               if (room) begin
                  mem_we    = 1'b1;
                  mem_waddr = count_ff[IDX_W-1:0];
                  mem_wdata = {1'b0, nr};
                  count_in  = count_ff + CNT_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
            end
            rem_in = rem_ff + 2'd1;
            if (rem_ff == REM_LAST) begin
               hidx_in = hidx_ff + CNT_W'(1);
            end
         end
         OP_SPLIT_END: i_in = '0;
         OP_PRUNE_RD_I: mem_re = 1'b1;
         OP_PRUNE_LATCH: begin
            ri_in = rd_ff[RECT_W-1:0];
            j_in  = i_ff + CNT_W'(1);
            if (rd_ff[RECT_W]) begin
               i_in = i_ff + CNT_W'(1);
            end
         end
         OP_PRUNE_NEXT_I: i_in = i_ff + CNT_W'(1);
         OP_PRUNE_RD_J: begin
            mem_re    = 1'b1;
            mem_raddr = j_ff[IDX_W-1:0];
         end
         OP_PRUNE_CHK: begin
            if (!rd_ff[RECT_W] && in_ij) begin
               mem_we    = 1'b1;
               mem_waddr = i_ff[IDX_W-1:0];
               mem_wdata = {1'b1, ri_ff};
               i_in      = i_ff + CNT_W'(1);
            end else if (!rd_ff[RECT_W] && in_ji) begin
               mem_we    = 1'b1;
               mem_waddr = j_ff[IDX_W-1:0];
               mem_wdata = {1'b1, rd_ff[RECT_W-1:0]};
               j_in      = j_ff + CNT_W'(1);
            end else begin
               j_in = j_ff + CNT_W'(1);
            end
         end
         OP_PRUNE_END: begin
            i_in  = '0;
            wp_in = '0;
         end
         OP_COMP_RD: mem_re = 1'b1;
         OP_COMP_WR: begin
            if (!rd_ff[RECT_W]) begin
               mem_we    = 1'b1;
               mem_waddr = wp_ff[IDX_W-1:0];
               wp_in     = wp_ff + CNT_W'(1);
            end
            i_in = i_ff + CNT_W'(1);
         end
         OP_COMP_END: count_in = wp_ff;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      i_ff         <= i_in;
      j_ff         <= j_in;
      wp_ff        <= wp_in;
      hcnt_ff      <= hcnt_in;
      hidx_ff      <= hidx_in;
      rem_ff       <= rem_in;
      w_ff         <= w_in;
      h_ff         <= h_in;
      found_ff     <= found_in;
      best_area_ff <= best_area_in;
      best_l_ff    <= best_l_in;
      best_t_ff    <= best_t_in;
      area_ff      <= area_in;
      fits_ff      <= fits_in;
      res_l_ff     <= res_l_in;
      res_t_ff     <= res_t_in;
      res_r_ff     <= res_r_in;
      res_b_ff     <= res_b_in;
      granted_ff   <= granted_in;
      ovf_ff       <= ovf_in;
      ri_ff        <= ri_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_ff <= mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (hold_we) begin
         hold_mem[hold_waddr] <= rd_ff[RECT_W-1:0];
      end
      if (hold_re) begin
         hrd_ff <= hold_mem[hidx_ff[IDX_W-1:0]];
      end
   end

   assign granted       = granted_ff;
   assign pos_x         = FIELD_W'(res_l_ff);
   assign pos_y         = FIELD_W'(res_t_ff);
   assign list_overflow = ovf_ff;

endmodule
